// ===== rtl/mwlfo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared types, constants and elaboration-time tables for the multi-waveform
// low-frequency oscillator.
// ----------------------------------------------------------------------------
package mwlfo_pkg;

  // widths and fixed-point scale
  localparam int PHASE_W     = 32;
  localparam int SAMPLE_W    = 16;
  localparam int WAVE_W      = SAMPLE_W + 1;
  localparam int DEPTH_W     = 17;
  localparam int SINE_ADDR_W = 8;
  localparam int SINE_LAST   = 1 << SINE_ADDR_W;
  localparam int SINE_IDX_W  = SINE_ADDR_W + 1;
  localparam int UNIT        = 1 << (SAMPLE_W - 1);
  localparam int CFG_IDX_W   = 2;
  localparam int SEL_W       = 3;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL  = DEPTH_W'(65536);
  localparam logic [31:0]        LFSR_SEED   = 32'hACE1_ACE1;
  localparam logic [31:0]        LFSR_TAPS   = 32'hD000_0001;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_WAVE_SELECT = 2'd1,
    CFG_MOD_DEPTH   = 2'd2
  } cfg_reg_e;

  // command codes
  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_LOAD    = 1'b1
  } cmd_e;

  // waveform codes, codes above random act as random
  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_RANDOM   = 3'd4
  } wave_sel_e;

  // channel payloads
  typedef struct packed {
    logic              command;
    logic [PHASE_W-1:0] phase_value;
  } mwlfo_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mod_sample;
    logic                       cycle_wrapped;
  } mwlfo_out_t;

  // quarter-wave sine table, entries 0..SINE_LAST, SAMPLE_W bits each
  typedef logic [(SINE_LAST+1)*SAMPLE_W-1:0] sine_tbl_t;

  // taylor series in Q30, seven terms, evaluated at elaboration
  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t          tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        v;
    logic signed [63:0] sum;
    tbl = '0;
    for (int i = 0; i <= SINE_LAST; i++) begin
      x   = (64'(i) * HALF_PI_Q30) >> SINE_ADDR_W;
      x2  = (x * x) >> 30;
      sum = $signed(x);
      t   = ((x * x2) >> 30) / 64'd6;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 64'd110;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 64'd156;
      sum = sum + $signed(t);
      if (sum < 0) begin
        sum = '0;
      end
      v = ($unsigned(sum) * 64'(UNIT) + (64'd1 << 29)) >> 30;
      if (v > 64'(UNIT)) begin
        v = 64'(UNIT);
      end
      tbl[i*SAMPLE_W +: SAMPLE_W] = v[SAMPLE_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

  // one random draw: SAMPLE_W galois steps, a linear xor network
  function automatic logic [31:0] lfsr_draw(logic [31:0] seed);
    logic [31:0] s;
    s = seed;
    for (int k = 0; k < SAMPLE_W; k++) begin
      s = (s >> 1) ^ ({32{s[0]}} & LFSR_TAPS);
    end
    return s;
  endfunction

endpackage

// ===== rtl/mwlfo_wave.sv =====
// ----------------------------------------------------------------------------
// mwlfo_wave
// Waveform shaper: maps the oscillator phase to one waveform value in
// Q1.15 with one extra bit of headroom, so that +1.0 is representable.
// ----------------------------------------------------------------------------
module mwlfo_wave (
  input  logic [mwlfo_pkg::PHASE_W-1:0]       phase_i,
  input  logic [mwlfo_pkg::SEL_W-1:0]         sel_i,
  input  logic signed [mwlfo_pkg::SAMPLE_W-1:0] held_i,
  output logic signed [mwlfo_pkg::WAVE_W-1:0]   wave_o
);
  import mwlfo_pkg::*;

  logic [1:0]             quad;
  logic [SINE_ADDR_W-1:0] idx_raw;
  logic [SINE_IDX_W-1:0]  sin_idx;
  logic [SAMPLE_W-1:0]    sin_mag;
  logic signed [WAVE_W-1:0] sin_val;
  logic [WAVE_W-1:0]      h;
  logic [WAVE_W:0]        tri_mid;
  logic signed [WAVE_W-1:0] tri_val;
  logic signed [WAVE_W-1:0] sq_val;
  logic signed [WAVE_W-1:0] saw_val;

  // sine: quadrant mirror and sign
  assign quad    = phase_i[PHASE_W-1 -: 2];
  assign idx_raw = phase_i[PHASE_W-3 -: SINE_ADDR_W];
  assign sin_idx = quad[0] ? (SINE_IDX_W'(SINE_LAST) - {1'b0, idx_raw}) : {1'b0, idx_raw};
  assign sin_mag = SINE_TBL[sin_idx*SAMPLE_W +: SAMPLE_W];
  assign sin_val = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});

  // triangle from the top bits of the phase
  assign h       = phase_i[PHASE_W-1 -: WAVE_W];
  assign tri_mid = (WAVE_W+1)'(2*UNIT) - {1'b0, h};
  always_comb begin
    if (h < WAVE_W'(UNIT)) begin
      tri_val = $signed(h);
    end else if (h < WAVE_W'(3*UNIT)) begin
      tri_val = $signed(tri_mid[WAVE_W-1:0]);
    end else begin
      // h - 4U wraps to h itself in WAVE_W bits
      tri_val = $signed(h);
    end
  end

  // square and rising saw
  assign sq_val  = phase_i[PHASE_W-1] ? -$signed(WAVE_W'(UNIT)) : $signed(WAVE_W'(UNIT));
  assign saw_val = $signed({1'b0, phase_i[PHASE_W-1 -: SAMPLE_W]}) - $signed(WAVE_W'(UNIT));

  // waveform select
  always_comb begin
    case (sel_i)
      WAVE_SINE:     wave_o = sin_val;
      WAVE_TRIANGLE: wave_o = tri_val;
      WAVE_SQUARE:   wave_o = sq_val;
      WAVE_SAW:      wave_o = saw_val;
      default:       wave_o = {held_i[SAMPLE_W-1], held_i};
    endcase
  end

endmodule

// ===== rtl/multi_waveform_lfo.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_lfo
// Low-frequency oscillator with sine, triangle, square, saw and random
// sample-and-hold outputs, scaled by depth/2. An advance command steps the
// 32-bit phase by phase_step and returns one sample with the wrap flag; a load
// command replaces the phase and returns nothing. The block takes one command
// per clock while in_stall_o is low. On the transfer edge the phase adder and
// random draw update the oscillator state and load the command register; the
// waveform shaper and the depth multiplier run between that register and the
// sample register, from which the sample is presented. A stall on the sample
// side holds the command side once both registers are full.
// Configuration writes are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
module multi_waveform_lfo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mwlfo_pkg::mwlfo_in_t          in_data_i,
  // sample channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mwlfo_pkg::mwlfo_out_t         out_data_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mwlfo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import mwlfo_pkg::*;

  // configuration
  logic [PHASE_W-1:0] phase_step_q;
  logic [SEL_W-1:0]   wave_select_q;
  logic [DEPTH_W-1:0] mod_depth_q;

  // oscillator state
  logic [PHASE_W-1:0]        phase_q, phase_d;
  logic [31:0]               lfsr_q, lfsr_d;
  logic signed [SAMPLE_W-1:0] held_q, held_d;
  logic [PHASE_W:0]          phase_sum;
  logic                      wrapped;
  logic                      draw;
  logic [31:0]               lfsr_next;

  // command register and sample register
  logic                      in_fire;
  logic                      s1_en, out_en;
  logic                      s1_valid_q, out_valid_q;
  logic [PHASE_W-1:0]        s1_phase_q;
  logic                      s1_wrapped_q;
  logic signed [SAMPLE_W-1:0] s1_held_q;
  logic signed [WAVE_W-1:0]  wave;
  logic [DEPTH_W-1:0]        depth_eff;
  logic signed [WAVE_W+DEPTH_W:0] prod;
  logic signed [WAVE_W+DEPTH_W:0] biased;
  mwlfo_out_t                out_q;

  // register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      wave_select_q <= '0;
      mod_depth_q   <= DEPTH_FULL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i[PHASE_W-1:0];
        CFG_WAVE_SELECT: wave_select_q <= cfg_data_i[SEL_W-1:0];
        CFG_MOD_DEPTH:   mod_depth_q   <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // register enables, a register loads when the one after it has room
  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_stall_o = !s1_en;
  assign in_fire    = in_valid_i && !in_stall_o;

  // phase advance and random draw on the transfer cycle
  assign phase_sum = {1'b0, phase_q} + {1'b0, phase_step_q};
  assign wrapped   = phase_sum[PHASE_W];
  assign draw      = (in_data_i.command == CMD_ADVANCE) && wrapped &&
                     (wave_select_q >= SEL_W'(WAVE_RANDOM));
  assign lfsr_next = lfsr_draw(lfsr_q);

  always_comb begin
    phase_d = phase_q;
    lfsr_d  = lfsr_q;
    held_d  = held_q;
    if (in_fire) begin
      if (in_data_i.command == CMD_LOAD) begin
        phase_d = in_data_i.phase_value;
      end else begin
        phase_d = phase_sum[PHASE_W-1:0];
        if (draw) begin
          lfsr_d = lfsr_next;
          held_d = $signed(lfsr_next[31 -: SAMPLE_W]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      lfsr_q  <= LFSR_SEED;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      lfsr_q  <= lfsr_d;
      held_q  <= held_d;
    end
  end

  // valid bits of the command and sample registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_fire && (in_data_i.command == CMD_ADVANCE);
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // waveform shaper
  mwlfo_wave u_wave (
    .phase_i (s1_phase_q),
    .sel_i   (wave_select_q),
    .held_i  (s1_held_q),
    .wave_o  (wave)
  );

  // depth scaling, rounded, depth above one saturates
  assign depth_eff = (mod_depth_q > DEPTH_FULL) ? DEPTH_FULL : mod_depth_q;
  assign prod      = (WAVE_W+DEPTH_W+1)'(wave) *
                     $signed((WAVE_W+DEPTH_W+1)'(depth_eff));
  assign biased    = prod + (WAVE_W+DEPTH_W+1)'(65536);

  // register payloads
  always_ff @(posedge clk_i) begin
    if (s1_en && in_fire && (in_data_i.command == CMD_ADVANCE)) begin
      s1_phase_q   <= phase_d;
      s1_wrapped_q <= wrapped;
      s1_held_q    <= held_d;
    end
    if (out_en && s1_valid_q) begin
      out_q.mod_sample    <= biased[DEPTH_W-1+SAMPLE_W:DEPTH_W];
      out_q.cycle_wrapped <= s1_wrapped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a load command never enters the sample path
  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.command == CMD_LOAD) |=> !s1_valid_q)
    else $error("load command produced a pipeline item");

  // the held random value moves only on an advance transfer
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && (in_data_i.command == CMD_ADVANCE)) |=> $stable(held_q))
    else $error("held random value changed without an advance");

  // the lfsr never locks up at zero
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("lfsr reached the all-zero state");

  // a registered command reaches the sample register when it has room
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_en |=> out_valid_q)
    else $error("sample lost between command and sample register");

  // a stalled sample holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled sample changed");
`endif

endmodule

// ===== tb/mwlfo_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwlfo_checker
// Watches the register, command and sample channels of the oscillator. It
// keeps its own copy of the phase, random source and registers, predicts one
// sample per advance command, and compares each sample transfer field by
// field with the oldest predicted sample.
// ----------------------------------------------------------------------------
module mwlfo_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  mwlfo_pkg::mwlfo_in_t            in_data_i,
  // sample channel
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  mwlfo_pkg::mwlfo_out_t           out_data_i,
  // register writes
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [mwlfo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  // status for the test top
  output int                              pending_o,
  output int                              fail_count_o,
  output int                              samples_o,
  output int                              wraps_o
);
  import mwlfo_pkg::*;

  localparam int   REPORT_LINES = 40;

  // quarter-wave sine values, entries 0..SINE_LAST
  int                         sine_quarter [0:SINE_LAST];

  // oscillator state and registers as the block should hold them
  logic [PHASE_W-1:0]         lfo_phase;
  logic [31:0]                noise_state;
  logic signed [SAMPLE_W-1:0] held_level;
  logic [31:0]                step_reg;
  logic [SEL_W-1:0]           wave_reg;
  logic [DEPTH_W-1:0]         depth_reg;

  mwlfo_out_t                 expected_samples [$];
  int                         fails;
  int                         checked;
  int                         wraps;

  // sin(pi/2 * i / 2^A) by a seven-term series in Q30, rounded to one unit
  function automatic void fill_sine_quarter();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          level;
    for (int i = 0; i <= SINE_LAST; i++) begin
      x    = (longint'(i) * HALF_PI_Q30) >> SINE_ADDR_W;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      level = (acc * UNIT + (longint'(1) << 29)) >>> 30;
      if (level > UNIT) begin
        level = UNIT;
      end
      sine_quarter[i] = int'(level);
    end
  endfunction

  // galois shift register stepped once per sample bit
  function automatic logic [31:0] noise_advance(logic [31:0] s);
    for (int k = 0; k < SAMPLE_W; k++) begin
      s = {1'b0, s[31:1]} ^ (s[0] ? LFSR_TAPS : 32'd0);
    end
    return s;
  endfunction

  // one tick: step the phase, shape the waveform, scale by depth/2
  function automatic mwlfo_out_t advance_oscillator();
    logic [PHASE_W:0] sum;
    logic             wrapped;
    int               h;
    int               level;
    int               depth_eff;
    int               idx;
    longint           prod;
    mwlfo_out_t       res;
    sum       = {1'b0, lfo_phase} + {1'b0, step_reg};
    wrapped   = sum[PHASE_W];
    lfo_phase = sum[PHASE_W-1:0];
    h         = int'(lfo_phase[PHASE_W-1 -: WAVE_W]);
    depth_eff = (depth_reg > DEPTH_FULL) ? int'(DEPTH_FULL) : int'(depth_reg);
    case (wave_reg)
      WAVE_SINE: begin
        idx = int'(lfo_phase[PHASE_W-3 -: SINE_ADDR_W]);
        if (lfo_phase[PHASE_W-2]) begin
          idx = SINE_LAST - idx;
        end
        level = sine_quarter[idx];
        if (lfo_phase[PHASE_W-1]) begin
          level = -level;
        end
      end
      WAVE_TRIANGLE: begin
        if (h < UNIT) begin
          level = h;
        end else if (h < 3 * UNIT) begin
          level = 2 * UNIT - h;
        end else begin
          level = h - 4 * UNIT;
        end
      end
      WAVE_SQUARE: begin
        level = (h < 2 * UNIT) ? UNIT : -UNIT;
      end
      WAVE_SAW: begin
        level = (h >> 1) - UNIT;
      end
      // random and the spare codes: new draw only on a wrapped tick
      default: begin
        if (wrapped) begin
          noise_state = noise_advance(noise_state);
          held_level  = noise_state[31 -: SAMPLE_W];
        end
        level = int'(held_level);
      end
    endcase
    prod              = longint'(level) * longint'(depth_eff);
    res.mod_sample    = SAMPLE_W'((prod + (longint'(1) << 16)) >>> 17);
    res.cycle_wrapped = wrapped;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fails < REPORT_LINES) begin
      $display("%0t ns: %s", $time, msg);
    end
    fails++;
  endtask

  initial begin
    fill_sine_quarter();
  end

  // follow every transfer at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    mwlfo_out_t want;
    if (!rst_ni) begin
      lfo_phase   = '0;
      noise_state = LFSR_SEED;
      held_level  = '0;
      step_reg    = '0;
      wave_reg    = WAVE_SINE;
      depth_reg   = DEPTH_FULL;
      expected_samples.delete();
      fails       = 0;
      checked     = 0;
      wraps       = 0;
    end else begin
      // sample transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with no command waiting",
                                    $signed(out_data_i.mod_sample)));
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (want.cycle_wrapped) begin
            wraps++;
          end
          if (out_data_i.mod_sample !== want.mod_sample) begin
            report_mismatch($sformatf("sample %0d: mod_sample %0d, expected %0d",
                                      checked, $signed(out_data_i.mod_sample),
                                      $signed(want.mod_sample)));
          end
          if (out_data_i.cycle_wrapped !== want.cycle_wrapped) begin
            report_mismatch($sformatf("sample %0d: cycle_wrapped %b, expected %b",
                                      checked, out_data_i.cycle_wrapped,
                                      want.cycle_wrapped));
          end
        end
      end
      // register write transfer
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PHASE_STEP:  step_reg  = cfg_data_i;
          CFG_WAVE_SELECT: wave_reg  = cfg_data_i[SEL_W-1:0];
          CFG_MOD_DEPTH:   depth_reg = cfg_data_i[DEPTH_W-1:0];
          default: ;
        endcase
      end
      // command transfer
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.command == CMD_LOAD) begin
          lfo_phase = in_data_i.phase_value;
        end else begin
          expected_samples.push_back(advance_oscillator());
        end
      end
    end
    pending_o    <= expected_samples.size();
    fail_count_o <= fails;
    samples_o    <= checked;
    wraps_o      <= wraps;
  end

endmodule

// ===== tb/tb_multi_waveform_lfo.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_waveform_lfo
// Drives the oscillator with directed and random advance and phase-load
// commands over many register settings, with random gaps on the command side
// and random stalls on the sample side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_multi_waveform_lfo;
  import mwlfo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam logic [SEL_W-1:0]     WAVE_SPARE   = 3'd7;
  localparam int                   RANDOM_ITEMS = 750;
  localparam int                   IDLE_LIMIT   = 2000;
  localparam int                   TAIL_CYCLES  = 10;
  localparam int                   SETTLE_WAIT  = 8;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  mwlfo_in_t            in_data     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  mwlfo_out_t           out_data;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [31:0]          cfg_data    = '0;

  int                   pending;
  int                   fail_count;
  int                   samples;
  int                   wraps;
  int                   sent        = 0;
  int                   loads       = 0;
  int                   reg_writes  = 0;
  int                   idle_cycles = 0;
  bit                   gaps_on     = 1'b0;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  multi_waveform_lfo u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mwlfo_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .samples_o    (samples),
    .wraps_o      (wraps)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [31:0] pick_phase();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3, 4, 5: return $urandom();
      6, 7:    return $urandom_range(0, 32'h0FFF_FFFF);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  // depth in the low bits, noise above them
  function automatic logic [31:0] pick_depth();
    logic [DEPTH_W-1:0] depth;
    case ($urandom_range(0, 7))
      0:       depth = '0;
      1:       depth = DEPTH_FULL;
      2:       depth = '1;
      3:       depth = DEPTH_W'($urandom_range(65537, 131071));
      default: depth = DEPTH_W'($urandom_range(0, 65536));
    endcase
    return {15'($urandom()), depth};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic send_cmd(input logic cmd, input logic [31:0] value);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid              <= 1'b1;
    in_data.command       <= cmd;
    in_data.phase_value   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (cmd == CMD_LOAD) begin
      loads++;
    end
  endtask

  // hold off commands until every predicted sample has come out
  task automatic drain_samples();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // idle point for register writes: drained, then past any trailing load
  task automatic settle();
    drain_samples();
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // sample-side stalls with occasional quiet stretches
  initial begin : stall_gen
    int busy;
    int free;
    busy = 0;
    free = 0;
    forever begin
      @(negedge clk);
      if (busy > 0) begin
        out_stall <= 1'b1;
        busy--;
      end else if (free > 0) begin
        out_stall <= 1'b0;
        free--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0) begin
          free = $urandom_range(80, 200);
        end else begin
          free = pick_gap();
          busy = pick_gap();
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d samples outstanding",
                 IDLE_LIMIT, pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int burst;
    int random_sent;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: sine at zero step
    send_cmd(CMD_ADVANCE, $urandom());

    // quarter-turn step visits every sine quadrant and ends on an exact wrap
    settle();
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    send_cmd(CMD_LOAD, '0);
    repeat (4) send_cmd(CMD_ADVANCE, $urandom());

    // triangle from the top phase with the largest step, wrapping every tick
    settle();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_TRIANGLE));
    write_reg(CFG_PHASE_STEP, '1);
    send_cmd(CMD_LOAD, '1);
    repeat (2) send_cmd(CMD_ADVANCE, $urandom());

    // square at zero depth
    settle();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_SQUARE));
    write_reg(CFG_MOD_DEPTH, '0);
    send_cmd(CMD_ADVANCE, $urandom());

    // saw with depth above one, which saturates
    settle();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_SAW));
    write_reg(CFG_MOD_DEPTH, 32'h0001_FFFF);
    send_cmd(CMD_LOAD, 32'h8000_0000);
    send_cmd(CMD_ADVANCE, $urandom());

    // sample and hold at half-turn step: draws on every other tick
    settle();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_RANDOM));
    write_reg(CFG_PHASE_STEP, 32'h8000_0000);
    write_reg(CFG_MOD_DEPTH, 32'(DEPTH_FULL));
    repeat (3) send_cmd(CMD_ADVANCE, $urandom());

    // spare selector code behaves as sample and hold
    settle();
    write_reg(CFG_WAVE_SELECT, 32'(WAVE_SPARE));
    repeat (2) send_cmd(CMD_ADVANCE, $urandom());

    // write to the unused register index changes nothing
    settle();
    write_reg(CFG_SPARE, $urandom());
    send_cmd(CMD_ADVANCE, $urandom());

    // random phases: new settings, then a burst of commands
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_PHASE_STEP, pick_step());
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_WAVE_SELECT, {29'($urandom()), 3'($urandom_range(0, 7))});
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_MOD_DEPTH, pick_depth());
      end
      if ($urandom_range(0, 15) == 0) begin
        write_reg(CFG_SPARE, $urandom());
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      burst   = $urandom_range(20, 80);
      for (int i = 0; i < burst; i++) begin
        if (i == burst / 2 && $urandom_range(0, 3) == 0) begin
          drain_samples();
        end
        if ($urandom_range(0, 99) < 12) begin
          send_cmd(CMD_LOAD, pick_phase());
        end else begin
          send_cmd(CMD_ADVANCE, $urandom());
        end
        random_sent++;
      end
    end

    // wait out the pipeline, then give the verdict
    drain_samples();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d commands (%0d phase loads) over %0d register writes",
             sent, loads, reg_writes);
    $display("checked %0d samples, %0d of them on a wrapped tick", samples, wraps);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
